FILE: hdl/int32_to_decimal_ascii_core_assert.svh
// assertion macros used by the int32_to_decimal_ascii_core rtl
// each macro expects clk and arst_n in the scope where it is used
`ifndef INT32_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define INT32_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define I2D_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define I2D_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define I2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/i2d_pkg.sv
// shared types, constants and helpers of the int32_to_decimal_ascii_core
// no dependencies
package i2d_pkg;

	// operand and digit register sizes
	localparam int BIN_W      = 32;
	localparam int MAX_DIGITS = 10;
	localparam int CNT_W      = $clog2(BIN_W);
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CHAR_W     = 8;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// character codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

	typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

	// classified item handed from front to back
	typedef struct packed {
		logic             neg;
		logic [BIN_W-1:0] mag;
	} i2d_item_t;

	// index of the highest nonzero digit, zero when all digits are zero
	function automatic logic [IDX_W-1:0] i2d_top_digit(input digits_t d);
		logic [IDX_W-1:0] top;
		top = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (d[i] != 4'd0)
				top = IDX_W'(i);
		end
		return top;
	endfunction

endpackage

FILE: hdl/i2d_fifo.sv
// short register queue between the front and back of the converter
// depends on i2d_pkg
module i2d_fifo
	import i2d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  i2d_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output i2d_item_t pop_item
);

	i2d_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: hdl/i2d_front.sv
// input side: takes a transaction, resolves the sign and forms the magnitude
// depends on i2d_pkg, feeds i2d_fifo
module i2d_front
	import i2d_pkg::*;
(
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [BIN_W-1:0] s_axis_tdata,
	input  logic             s_axis_tuser,
	input  logic             q_full,
	output logic             push,
	output i2d_item_t        push_item
);

	logic neg;

	// signed mode with the top bit set means a negative value
	assign neg = s_axis_tuser & s_axis_tdata[BIN_W-1];

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	// magnitude wraps so that the most negative value stays as its pattern
	assign push_item.neg = neg;
	assign push_item.mag = neg ? (BIN_W'(0) - s_axis_tdata) : s_axis_tdata;

endmodule

FILE: hdl/i2d_back.sv
// back side: shift-and-add-3 conversion, then one character per transaction
// depends on i2d_pkg and int32_to_decimal_ascii_core_assert.svh
`include "int32_to_decimal_ascii_core_assert.svh"

module i2d_back
	import i2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  i2d_item_t         q_item,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [CHAR_W-1:0] m_axis_tdata,
	output logic              m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    sign_q;
	logic                    out_valid_q;
	logic [BIN_W-1:0]        bin_q;
	digits_t                 bcd_q;
	digits_t                 bcd_adj;
	logic [4*MAX_DIGITS-1:0] bcd_adj_flat;
	logic [IDX_W-1:0]        idx_q;
	logic [CHAR_W-1:0]       out_data_q;
	logic                    out_last_q;
	logic                    out_free;
	logic                    emit;
	logic [CHAR_W-1:0]       digit_char;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || m_axis_tready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	assign digit_char = ASCII_ZERO + CHAR_W'(bcd_q[idx_q]);

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++)
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
	end

	// adjusted digits as one flat vector for the shift
	assign bcd_adj_flat = bcd_adj;

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						sign_q  <= q_item.neg;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(BIN_W - 1))
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (sign_q)
							sign_q <= 1'b0;
						else if (idx_q == '0)
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: binary shifter, digit register, digit index, output data
	always_ff @(posedge clk) begin
		if (pop) begin
			bin_q <= q_item.mag;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= bin_q << 1;
			bcd_q <= {bcd_adj_flat[4*MAX_DIGITS-2:0], bin_q[BIN_W-1]};
		end
		if (state_q == ST_SCAN)
			idx_q <= i2d_top_digit(bcd_q);
		else if (emit && !sign_q && idx_q != '0)
			idx_q <= idx_q - 1'b1;
		if (emit) begin
			out_data_q <= sign_q ? ASCII_MINUS : digit_char;
			out_last_q <= !sign_q && (idx_q == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// checks on sequencing and emitted characters
	`I2D_ASSERT_IMPL(a_minus_not_last, out_valid_q && out_data_q == ASCII_MINUS, !out_last_q, "minus sign flagged as last")
	`I2D_ASSERT_IMPL(a_char_range, out_valid_q, out_data_q == ASCII_MINUS || (out_data_q >= ASCII_ZERO && out_data_q <= ASCII_NINE), "character outside minus and digits")
	`I2D_ASSERT_IMPL(a_idle_no_sign, state_q == ST_IDLE, !sign_q, "sign still owed between items")
	`I2D_ASSERT_NEXT(a_conv_runs, state_q == ST_CONV && cnt_q != CNT_W'(BIN_W - 1), state_q == ST_CONV, "conversion left early")

endmodule

FILE: hdl/int32_to_decimal_ascii_core.sv
// Converts a 32-bit value, unsigned or two's complement as selected by s_axis_tuser, into its
// decimal ASCII characters, most significant first, leading zeros dropped, a leading '-' for
// negative signed values, and m_axis_tlast on the final digit; zero prints as one '0'. The
// front accepts a transaction whenever its two-entry queue has room. The back takes one item
// at a time: a load step, a shift-and-add-3 pass over all 32 bits in the digit register, a
// scan for the top digit, then one character per cycle while the output is not stalled.
// depends on i2d_pkg, i2d_fifo, i2d_front, i2d_back
module int32_to_decimal_ascii_core
	import i2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BIN_W-1:0]  s_axis_tdata,   // [31:0] value
	input  logic              s_axis_tuser,   // [0] func: 1 = signed
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [CHAR_W-1:0] m_axis_tdata,   // [7:0] char_code
	output logic              m_axis_tlast
);

	logic      q_full;
	logic      push;
	i2d_item_t push_item;
	logic      pop;
	logic      q_valid;
	i2d_item_t q_item;

	// sign resolution and input handshake
	i2d_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	// decoupling queue
	i2d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// conversion and character output
	i2d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
